/* sv/lpbs_pkg.sv */
// Package for the LED pixel buffer scaler: constants, types and helpers.
// No dependencies.
`default_nettype none
package lpbs_pkg;
  localparam int unsigned MaxPixelsDef = 256;
  localparam logic [7:0] TypeWordRst = 8'd82;
  localparam logic [1:0] CfgTypeWord = 2'd0;
  localparam logic [1:0] CfgBright = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;
  localparam logic ModeSet = 1'b0;
  localparam logic ModeGet = 1'b1;

  // One classified item handed from the front part to the back part.
  // The byte base is kept wide enough for any pixel count the register allows.
  typedef struct packed {
    logic        ok;
    logic        mode;
    logic [10:0] base;
    logic        rgbw;
    logic [31:0] color;
  } cmd_t;

  // True when the white and red byte positions coincide.
  function automatic logic three_of(input logic [7:0] tw);
    three_of = (tw[7:6] == tw[5:4]);
  endfunction
endpackage
`default_nettype wire

/* sv/lpbs_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module lpbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // Read first: read data is registered and shows the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

/* sv/lpbs_front.sv */
// Front part: range check and byte base computation, into a two-entry queue.
// Depends on lpbs_pkg.
`default_nettype none
module lpbs_front
  import lpbs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MaxPixelsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [9:0]  pixel_index,
  input  wire logic [31:0] color_in,
  input  wire logic [7:0]  type_word,
  input  wire logic [8:0]  pixel_count,
  output logic             q_valid,
  input  wire logic        q_ready,
  output cmd_t             q_cmd
);
  // Compare width covers the pixel index, the count register and MAX_PIXELS.
  localparam int unsigned CB = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CW = (CB > 10) ? CB : 10;
  localparam logic [CW-1:0] MaxC = CW'(MAX_PIXELS);

  cmd_t        cmd;
  cmd_t        slot_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic [CW-1:0] cnt_in, effc;
  logic [11:0] base_full;
  logic        push, pop;

  // Classify the item.
  always_comb begin
    cnt_in = CW'(pixel_count);
    effc = (cnt_in > MaxC) ? MaxC : cnt_in;
    base_full = three_of(type_word) ? ({2'b0, pixel_index} * 12'd3)
                                    : {pixel_index, 2'b00};
    cmd.ok = (CW'(pixel_index) < effc);
    cmd.mode = mode;
    cmd.base = base_full[10:0];
    cmd.rgbw = !three_of(type_word);
    cmd.color = color_in;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = slot_r[rp_r];

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cmd;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd2) |=> (cnt_r != 2'd0))
    else $error("full queue emptied at once");
endmodule
`default_nettype wire

/* sv/lpbs_back.sv */
// Back part: sequencer over the byte store, scaling, divider and output register.
// Depends on lpbs_pkg and lpbs_ram.
`default_nettype none
module lpbs_back
  import lpbs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MaxPixelsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  input  wire logic [7:0]  type_word,
  input  wire logic [7:0]  brightness,
  input  wire logic        clr_req,
  output logic             busy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [77:0]      out_data
);
  localparam int unsigned DEPTH = MAX_PIXELS * 4;
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_WR   = 7'b0000100,
    S_RD   = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_HOLD = 7'b1000000
  } st_t;

  st_t         st_r, st_nxt;
  cmd_t        cmd_r;
  logic [AW:0] clr_r;
  logic [2:0]  k_r;
  logic [7:0]  byte_r [4];
  logic [31:0] col_r;
  logic [1:0]  ch_r;
  logic [3:0]  dstep_r;
  logic [15:0] rem_r;
  logic [7:0]  quo_r;
  logic        we;
  logic [AW-1:0] addr;
  logic [7:0]  wdata, rdata;
  logic [2:0]  len;
  logic [1:0]  pos [4];
  logic [7:0]  cval [4];
  logic [15:0] prod;
  logic [7:0]  sbyte;
  logic [11:0] a_full;
  logic        hit;
  logic [7:0]  rawb;
  logic [8:0]  trial;
  logic [7:0]  chv;
  logic [31:0] oc_nxt;
  logic        has_ch [4];

  assign len = cmd_r.rgbw ? 3'd4 : 3'd3;
  assign pos[0] = type_word[7:6];
  assign pos[1] = type_word[5:4];
  assign pos[2] = type_word[3:2];
  assign pos[3] = type_word[1:0];
  assign cval[0] = cmd_r.color[31:24];
  assign cval[1] = cmd_r.color[23:16];
  assign cval[2] = cmd_r.color[15:8];
  assign cval[3] = cmd_r.color[7:0];
  assign has_ch[0] = cmd_r.rgbw;
  assign has_ch[1] = 1'b1;
  assign has_ch[2] = 1'b1;
  assign has_ch[3] = 1'b1;

  // Scaled byte of the channel whose position is k_r: the byte that lands at position k_r.
  always_comb begin
    hit = 1'b0;
    sbyte = 8'd0;
    for (int c = 0; c < 4; c++) begin
      if (has_ch[c] && (3'(pos[c]) == k_r) && (3'(pos[c]) < len)) begin
        hit = 1'b1;
        prod = cval[c] * brightness;
        sbyte = (brightness == 8'd0) ? cval[c] : prod[15:8];
      end
    end
    prod = cval[0] * brightness;
  end

  assign a_full = {1'b0, cmd_r.base} + {9'b0, k_r};
  assign addr = (st_r == S_CLR) ? clr_r[AW-1:0] : AW'(a_full);
  assign we = (st_r == S_CLR) ||
              ((st_r == S_WR) && hit && (32'(a_full) < DEPTH) && (k_r < len));
  assign wdata = (st_r == S_CLR) ? 8'd0 : sbyte;

  lpbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Raw stored byte of channel ch_r, zero when its position is not stored.
  always_comb begin
    rawb = (3'(pos[ch_r]) < len) ? byte_r[pos[ch_r]] : 8'd0;
    trial = {rem_r[14:7], quo_r[7] & 1'b0} ;
    trial = rem_r[15:7] - {1'b0, brightness};
    chv = (brightness == 8'd0) ? rawb : quo_r;
  end

  assign q_ready = (st_r == S_IDLE) && !clr_req;
  assign busy = (st_r != S_IDLE);

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR:  if (clr_r == (AW+1)'(DEPTH - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (clr_req) st_nxt = S_CLR;
        else if (q_valid) st_nxt = !q_cmd.ok ? S_OUT
                                 : (q_cmd.mode == ModeSet) ? S_WR : S_RD;
      end
      S_WR:   if (k_r == 3'd3) st_nxt = S_RD;
      S_RD:   if (k_r == 3'd4) st_nxt = (cmd_r.mode == ModeGet) ? S_DIV : S_OUT;
      S_DIV:  if (dstep_r == 4'd9 && ch_r == 2'd3) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_HOLD;
      S_HOLD: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    oc_nxt = col_r;
    if (has_ch[ch_r]) oc_nxt[8*(3-ch_r) +: 8] = chv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE && clr_req) clr_r <= '0;
      else if (st_r == S_CLR) clr_r <= clr_r + 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        cmd_r <= q_cmd;
        k_r <= 3'd0;
        ch_r <= 2'd0;
        dstep_r <= 4'd0;
        col_r <= '0;
      end
      S_WR: k_r <= (k_r == 3'd3) ? 3'd0 : k_r + 3'd1;
      S_RD: begin
        k_r <= k_r + 3'd1;
        if (k_r != 3'd0) begin
          byte_r[k_r[1:0] - 2'd1] <= ((k_r - 3'd1) < len &&
              32'({1'b0, cmd_r.base} + 12'(k_r - 3'd1)) < DEPTH) ? rdata : 8'd0;
        end
      end
      S_DIV: begin
        // Restoring division of (v<<8) by brightness, one bit per step.
        if (dstep_r == 4'd0) begin
          rem_r <= {rawb, 8'd0};
          quo_r <= 8'd0;
          dstep_r <= 4'd1;
          if (rawb >= brightness && brightness != 8'd0) begin
            quo_r <= 8'hFF;
            dstep_r <= 4'd9;
          end
        end else if (dstep_r != 4'd9) begin
          if (rem_r[15:7] >= {1'b0, brightness}) begin
            rem_r <= {trial[7:0], rem_r[6:0], 1'b0};
            quo_r <= {quo_r[6:0], 1'b1};
          end else begin
            rem_r <= {rem_r[14:0], 1'b0};
            quo_r <= {quo_r[6:0], 1'b0};
          end
          dstep_r <= dstep_r + 4'd1;
        end else begin
          col_r <= oc_nxt;
          ch_r <= ch_r + 2'd1;
          dstep_r <= 4'd0;
        end
      end
      S_OUT: begin
        out_data <= cmd_r.ok ?
          {cmd_r.mode == ModeGet ? col_r : 32'd0,
           byte_r[3] & {8{cmd_r.rgbw}}, byte_r[2], byte_r[1], byte_r[0],
           cmd_r.mode == ModeSet ? len : 3'd0, cmd_r.base[9:0], 1'b1} : 78'd0;
      end
      default: ;
    endcase
  end

  assign out_valid = (st_r == S_HOLD);

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !q_ready)
    else $error("new item taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == S_CLR) |-> !out_valid)
    else $error("output during clear");
endmodule
`default_nettype wire

/* sv/led_pixel_buffer_scaler.sv */
// Top level of the LED pixel buffer scaler: config registers, front and back parts.
// Depends on lpbs_pkg, lpbs_front, lpbs_back.
`default_nettype none
// Items are carried out one at a time; the front queue holds two more words. A set
// writes the scaled bytes to the byte store and reads them back, a get reads the
// stored bytes back and then runs the divider for each color channel, with a
// shortcut when the channel saturates at once, and an item with a bad index goes
// straight to the output register. After reset, and after any pixel count change
// or a change between 3- and 4-byte pixels, a clearing pass over all MAX_PIXELS*4
// bytes of the store runs before items are taken again.
module led_pixel_buffer_scaler
  import lpbs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MaxPixelsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // mode, pixel_index, color_in, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata, // index_ok, byte_offset, byte_count,
                                      // stored_bytes, color_out, zero pad
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);
  logic [7:0] type_r, bright_r;
  logic [8:0] count_r;
  logic       clr_r;
  logic       q_valid, q_ready, busy;
  cmd_t       q_cmd;
  logic [77:0] od;

  // Configuration registers and clear request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= TypeWordRst;
      bright_r <= 8'd0;
      count_r <= 9'd0;
      clr_r <= 1'b0;
    end else begin
      if (q_ready || !busy) clr_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTypeWord: begin
            type_r <= cfg_wdata[7:0];
            if (three_of(cfg_wdata[7:0]) != three_of(type_r)) clr_r <= 1'b1;
          end
          CfgBright: bright_r <= cfg_wdata[7:0];
          CfgCount: begin
            count_r <= cfg_wdata;
            if (cfg_wdata != count_r) clr_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  lpbs_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tdata[0]), .pixel_index(in_tdata[10:1]), .color_in(in_tdata[42:11]),
    .type_word(type_r), .pixel_count(count_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  lpbs_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .type_word(type_r), .brightness(bright_r), .clr_req(clr_r), .busy(busy),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(od)
  );

  assign out_tdata = {2'b00, od};

  assert property (@(posedge clk) disable iff (!rst_n)
      (cfg_we && cfg_index == CfgCount && cfg_wdata != count_r) |=> clr_r)
    else $error("count change did not request clear");
  assert property (@(posedge clk) disable iff (!rst_n) clr_r |-> !q_ready)
    else $error("item taken while clear pending");
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
